/* src/crss_pkg.sv */
// Shared types and constants for the Catmull-Rom stroke sampler.
package crss_pkg;

  // Segment subdivision limit and the width of step counters.
  localparam int MAX_STEPS = 31;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVATURE = 1'b1;

  // Register reset values.
  localparam logic [15:0] SPACING_RST   = 16'd16;
  localparam logic [8:0]  CURVATURE_RST = 9'd256;

  // One control point.
  typedef struct packed {
    logic signed [15:0] ctrl_x;
    logic signed [15:0] ctrl_y;
    logic [15:0]        ctrl_pressure;
    logic               stroke_end;
  } in_item_t;

  // One sample.
  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic [15:0]        sample_pressure;
    logic               run_last;
  } out_item_t;

endpackage

/* src/catmull_rom_stroke_sampler_top.sv */
// Catmull-Rom stroke sampler: sequencer around one shared 24x18 multiplier.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_item_t  (control point)
//   out_     out  out_valid/out_stall out_item_t (sample)
//   cfg_     in   cfg_valid/cfg_ready index + 16-bit data (spacing, curvature)
//
// One item at a time; in_stall is low only in the idle state.
// Per segment: a load, the chord and spacing squares on the multiplier, a step
// search over 1 to 31 steps, a reciprocal division and an init, then per
// sample 22 multiplier/adder steps and one output load. The shared
// multiplier paces the samples; a stalled output holds the sequencer.
// Synchronous active-low reset clears the control registers only; datapath registers are not reset; no clearing pass.
module catmull_rom_stroke_sampler_top import crss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_LOAD  = 12'b000000000010,
    ST_D2X   = 12'b000000000100,
    ST_D2Y   = 12'b000000001000,
    ST_SSQ   = 12'b000000010000,
    ST_SRCH  = 12'b000000100000,
    ST_DIV   = 12'b000001000000,
    ST_TINIT = 12'b000010000000,
    ST_SAMP  = 12'b000100000000,
    ST_EMIT  = 12'b001000000000,
    ST_ECHO  = 12'b010000000000,
    ST_FIN   = 12'b100000000000
  } state_t;

  // Per-axis segment coefficients.
  typedef struct packed {
    logic signed [16:0] a;
    logic signed [19:0] b;
    logic signed [18:0] c;
    logic signed [16:0] dl;
    logic signed [15:0] p1;
  } coef_t;

  // Sample micro-steps for one axis.
  localparam logic [3:0] PH_S2   = 4'd0;
  localparam logic [3:0] PH_S1H  = 4'd1;
  localparam logic [3:0] PH_S1L  = 4'd2;
  localparam logic [3:0] PH_CVH  = 4'd3;
  localparam logic [3:0] PH_CVL  = 4'd4;
  localparam logic [3:0] PH_LIN  = 4'd5;
  localparam logic [3:0] PH_DIF  = 4'd6;
  localparam logic [3:0] PH_VH   = 4'd7;
  localparam logic [3:0] PH_VL   = 4'd8;
  localparam logic [3:0] PH_RND  = 4'd9;
  // Pressure micro-steps.
  localparam logic [3:0] PH_PMUL = 4'd0;
  localparam logic [3:0] PH_PSAT = 4'd1;

  localparam logic [1:0] PART_X  = 2'd0;
  localparam logic [1:0] PART_Y  = 2'd1;
  localparam logic [1:0] PART_PR = 2'd2;

  localparam logic SEL_A = 1'b0;  // segment ending at the previous control
  localparam logic SEL_B = 1'b1;  // closing segment at stroke end

  localparam logic [STEP_W-1:0] STEPS_LIM = STEP_W'(MAX_STEPS);
  localparam logic [4:0]        DIV_TOP   = 5'd16;

  // Control registers.
  state_t            state_r;
  logic              out_valid_r;
  logic [1:0]        cc_r;
  logic [15:0]       spacing_r;
  logic [8:0]        curvature_r;
  logic [3:0]        ph_r;
  logic [1:0]        part_r;
  logic [STEP_W-1:0] i_r;
  logic [STEP_W-1:0] m_r;
  logic [4:0]        dc_r;
  logic              sel_r;
  logic              segb_r;

  // Datapath registers.
  in_item_t           item_r;
  out_item_t          out_data_r;
  coef_t              co_r [2];
  logic [15:0]        pr1_r;
  logic signed [16:0] dpr_r;
  logic [33:0]        d2_r;
  logic [43:0]        q_r;
  logic [43:0]        inc_r;
  logic [43:0]        ss2_r;
  logic [STEP_W-1:0]  steps_r;
  logic [16:0]        quo_r;
  logic [4:0]         rem_r;
  logic [16:0]        t_r;
  logic [4:0]         r_r;
  logic signed [47:0] acc_s_r;
  logic signed [47:0] acc_s1_r;
  logic signed [47:0] acc_c_r;
  logic signed [47:0] acc_l_r;
  logic signed [47:0] acc_v_r;
  logic signed [15:0] smp_x_r;
  logic signed [15:0] smp_y_r;
  logic [15:0]        smp_p_r;
  logic signed [15:0] win_x_r [3];
  logic signed [15:0] win_y_r [3];
  logic [15:0]        win_p_r [3];

  // Combinational helpers.
  logic signed [23:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [41:0] prod;
  logic signed [47:0] prod48;
  logic [15:0]        s_eff;
  logic [8:0]         cv_eff;
  logic               out_free;
  logic               srch_hit;
  logic [5:0]         rem_sh;
  logic               div_ge;
  logic [5:0]         rem_sub;
  logic               seg_end;
  logic               seg_first;
  logic               seg_last;
  logic [5:0]         ru_sum;
  logic               ru_ge;
  logic [5:0]         ru_sub;
  logic               ax;
  coef_t              co_cur;
  coef_t              lx;
  coef_t              ly;
  logic signed [47:0] rnd_v;
  logic signed [47:0] p_sh;
  logic signed [15:0] rnd_sat;

  function automatic coef_t calc_coef(input logic signed [15:0] p0,
                                      input logic signed [15:0] p1,
                                      input logic signed [15:0] p2,
                                      input logic signed [15:0] p3);
    logic signed [19:0] e0, e1, e2, e3;
    logic signed [19:0] ta, tb, tc, td;
    coef_t              r;
    e0 = 20'(p0);
    e1 = 20'(p1);
    e2 = 20'(p2);
    e3 = 20'(p3);
    ta = e2 - e0;
    tb = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    tc = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
    td = e2 - e1;
    r.a  = ta[16:0];
    r.b  = tb;
    r.c  = tc[18:0];
    r.dl = td[16:0];
    r.p1 = p1;
    return r;
  endfunction

  // Effective register values and the output free condition.
  assign s_eff    = (spacing_r < 16'd2) ? 16'd2 : spacing_r;
  assign cv_eff   = (curvature_r > 9'd256) ? 9'd256 : curvature_r;
  assign out_free = !out_valid_r || !out_stall;

  // Step search, reciprocal division and parameter advance.
  assign srch_hit  = (q_r >= {10'b0, d2_r}) || (m_r == STEPS_LIM);
  assign rem_sh    = {rem_r, (dc_r == DIV_TOP)};
  assign div_ge    = rem_sh >= {1'b0, steps_r};
  assign rem_sub   = rem_sh - {1'b0, steps_r};
  assign seg_end   = (i_r == steps_r);
  assign seg_first = (sel_r == SEL_A) ? (cc_r == 2'd2) : (cc_r == 2'd1);
  assign seg_last  = !((sel_r == SEL_A) && segb_r);
  assign ru_sum    = {1'b0, r_r} + {1'b0, rem_r};
  assign ru_ge     = ru_sum >= {1'b0, steps_r};
  assign ru_sub    = ru_sum - {1'b0, steps_r};
  assign ax        = part_r[0];
  assign co_cur    = co_r[ax];

  // Select segment control points.
  always_comb begin
    if (sel_r == SEL_A) begin
      lx = calc_coef((cc_r == 2'd2) ? win_x_r[1] : win_x_r[0], win_x_r[1], win_x_r[2],
                     item_r.ctrl_x);
      ly = calc_coef((cc_r == 2'd2) ? win_y_r[1] : win_y_r[0], win_y_r[1], win_y_r[2],
                     item_r.ctrl_y);
    end else begin
      lx = calc_coef((cc_r == 2'd1) ? win_x_r[2] : win_x_r[1], win_x_r[2], item_r.ctrl_x,
                     item_r.ctrl_x);
      ly = calc_coef((cc_r == 2'd1) ? win_y_r[2] : win_y_r[1], win_y_r[2], item_r.ctrl_y,
                     item_r.ctrl_y);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_D2X: begin
        mul_a = 24'(co_r[0].dl);
        mul_b = 18'(co_r[0].dl);
      end
      ST_D2Y: begin
        mul_a = 24'(co_r[1].dl);
        mul_b = 18'(co_r[1].dl);
      end
      ST_SSQ: begin
        mul_a = {8'b0, s_eff};
        mul_b = {2'b0, s_eff};
      end
      ST_SAMP: begin
        mul_b = {1'b0, t_r};
        if (part_r == PART_PR) begin
          mul_a = 24'(dpr_r);
        end else begin
          case (ph_r)
            PH_S2:  mul_a = 24'(co_cur.c);
            PH_S1H: mul_a = acc_s_r[39:16];
            PH_S1L: mul_a = {8'b0, acc_s_r[15:0]};
            PH_CVH: mul_a = acc_s1_r[39:16];
            PH_CVL: mul_a = {8'b0, acc_s1_r[15:0]};
            PH_LIN: mul_a = 24'(co_cur.dl);
            PH_VH: begin
              mul_a = acc_c_r[39:16];
              mul_b = {9'b0, cv_eff};
            end
            PH_VL: begin
              mul_a = {8'b0, acc_c_r[15:0]};
              mul_b = {9'b0, cv_eff};
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod48 = 48'(prod);

  // Round and saturate the blended position; shift down and clamp the rounded pressure.
  assign rnd_v = acc_v_r + 48'sd16777216;
  assign p_sh  = acc_s_r >>> 16;
  always_comb begin
    if ((rnd_v >>> 25) > 48'sd32767) begin
      rnd_sat = 16'sh7fff;
    end else if ((rnd_v >>> 25) < -48'sd32768) begin
      rnd_sat = -16'sh8000;
    end else begin
      rnd_sat = rnd_v[40:25];
    end
  end

  // Sequencer and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cc_r        <= 2'd0;
      spacing_r   <= SPACING_RST;
      curvature_r <= CURVATURE_RST;
      ph_r        <= PH_S2;
      part_r      <= PART_X;
      i_r         <= '0;
      m_r         <= '0;
      dc_r        <= '0;
      sel_r       <= SEL_A;
      segb_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SPACING:   spacing_r   <= cfg_data;
          CFG_CURVATURE: curvature_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      // Drop the output item once taken.
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            segb_r <= in_data.stroke_end && (cc_r != 2'd0);
            if (cc_r >= 2'd2) begin
              sel_r   <= SEL_A;
              state_r <= ST_LOAD;
            end else if (in_data.stroke_end && (cc_r != 2'd0)) begin
              sel_r   <= SEL_B;
              state_r <= ST_LOAD;
            end else if (in_data.stroke_end) begin
              state_r <= ST_ECHO;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_LOAD: state_r <= ST_D2X;
        ST_D2X:  state_r <= ST_D2Y;
        ST_D2Y:  state_r <= ST_SSQ;
        ST_SSQ: begin
          m_r     <= STEP_W'(1);
          state_r <= ST_SRCH;
        end
        ST_SRCH: begin
          if (srch_hit) begin
            dc_r    <= DIV_TOP;
            state_r <= ST_DIV;
          end else begin
            m_r <= m_r + STEP_W'(1);
          end
        end
        ST_DIV: begin
          if (dc_r == 5'd0) begin
            state_r <= ST_TINIT;
          end else begin
            dc_r <= dc_r - 5'd1;
          end
        end
        ST_TINIT: begin
          // The first segment of a stroke starts at t = 0, later ones one step in.
          i_r     <= seg_first ? STEP_W'(0) : STEP_W'(1);
          part_r  <= PART_X;
          ph_r    <= PH_S2;
          state_r <= ST_SAMP;
        end
        ST_SAMP: begin
          if (part_r == PART_PR) begin
            if (ph_r == PH_PSAT) begin
              state_r <= ST_EMIT;
            end else begin
              ph_r <= ph_r + 4'd1;
            end
          end else if (ph_r == PH_RND) begin
            part_r <= part_r + 2'd1;
            ph_r   <= PH_S2;
          end else begin
            ph_r <= ph_r + 4'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (seg_end) begin
              if (!seg_last) begin
                sel_r   <= SEL_B;
                state_r <= ST_LOAD;
              end else begin
                state_r <= ST_FIN;
              end
            end else begin
              i_r     <= i_r + STEP_W'(1);
              part_r  <= PART_X;
              ph_r    <= PH_S2;
              state_r <= ST_SAMP;
            end
          end
        end
        ST_ECHO: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (item_r.stroke_end) begin
            cc_r <= 2'd0;
          end else if (cc_r != 2'd3) begin
            cc_r <= cc_r + 2'd1;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath: item, window, segment setup, sample arithmetic, output item.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_r <= in_data;
        end
      end
      ST_LOAD: begin
        co_r[0] <= lx;
        co_r[1] <= ly;
        if (sel_r == SEL_A) begin
          pr1_r <= win_p_r[1];
          dpr_r <= $signed({1'b0, win_p_r[2]}) - $signed({1'b0, win_p_r[1]});
        end else begin
          pr1_r <= win_p_r[2];
          dpr_r <= $signed({1'b0, item_r.ctrl_pressure}) - $signed({1'b0, win_p_r[2]});
        end
      end
      ST_D2X: d2_r <= prod[33:0];
      ST_D2Y: d2_r <= d2_r + prod[33:0];
      ST_SSQ: begin
        q_r   <= {12'b0, prod[31:0]};
        inc_r <= {12'b0, prod[31:0]} + {11'b0, prod[31:0], 1'b0};
        ss2_r <= {11'b0, prod[31:0], 1'b0};
      end
      ST_SRCH: begin
        if (srch_hit) begin
          steps_r <= m_r;
          rem_r   <= '0;
          quo_r   <= '0;
        end else begin
          q_r   <= q_r + inc_r;
          inc_r <= inc_r + ss2_r;
        end
      end
      ST_DIV: begin
        rem_r <= div_ge ? rem_sub[4:0] : rem_sh[4:0];
        quo_r <= {quo_r[15:0], div_ge};
      end
      ST_TINIT: begin
        t_r <= seg_first ? 17'd0 : quo_r;
        r_r <= seg_first ? 5'd0 : rem_r;
      end
      ST_SAMP: begin
        if (part_r == PART_PR) begin
          if (ph_r == PH_PMUL) begin
            acc_s_r <= $signed({16'b0, pr1_r, 16'b0}) + prod48 + 48'sd32768;
          end else if (p_sh[47]) begin
            smp_p_r <= 16'd0;
          end else if (p_sh > 48'sd65535) begin
            smp_p_r <= 16'hffff;
          end else begin
            smp_p_r <= p_sh[15:0];
          end
        end else begin
          case (ph_r)
            PH_S2:  acc_s_r  <= $signed({{12{co_cur.b[19]}}, co_cur.b, 16'b0}) + prod48;
            PH_S1H: acc_s1_r <= $signed({{15{co_cur.a[16]}}, co_cur.a, 16'b0}) + prod48;
            PH_S1L: acc_s1_r <= acc_s1_r + (prod48 >>> 16);
            PH_CVH: acc_c_r  <= $signed({{15{co_cur.p1[15]}}, co_cur.p1, 17'b0}) + prod48;
            PH_CVL: acc_c_r  <= acc_c_r + (prod48 >>> 16);
            PH_LIN: acc_l_r  <= ($signed({{16{co_cur.p1[15]}}, co_cur.p1, 16'b0}) + prod48)
                                <<< 1;
            PH_DIF: acc_c_r  <= acc_c_r - acc_l_r;
            PH_VH:  acc_v_r  <= $signed({acc_l_r[39:0], 8'b0})
                                + $signed({prod48[31:0], 16'b0});
            PH_VL:  acc_v_r  <= acc_v_r + prod48;
            PH_RND: begin
              if (ax) begin
                smp_y_r <= rnd_sat;
              end else begin
                smp_x_r <= rnd_sat;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_r.sample_x        <= smp_x_r;
          out_data_r.sample_y        <= smp_y_r;
          out_data_r.sample_pressure <= smp_p_r;
          out_data_r.run_last        <= seg_end && seg_last;
          // Advance the sample parameter by the segment reciprocal.
          if (!seg_end) begin
            if (ru_ge) begin
              t_r <= t_r + quo_r + 17'd1;
              r_r <= ru_sub[4:0];
            end else begin
              t_r <= t_r + quo_r;
              r_r <= ru_sum[4:0];
            end
          end
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          out_data_r.sample_x        <= item_r.ctrl_x;
          out_data_r.sample_y        <= item_r.ctrl_y;
          out_data_r.sample_pressure <= item_r.ctrl_pressure;
          out_data_r.run_last        <= 1'b1;
        end
      end
      ST_FIN: begin
        // Shift the window unless the stroke closes.
        if (!item_r.stroke_end) begin
          win_x_r[0] <= win_x_r[1];
          win_x_r[1] <= win_x_r[2];
          win_x_r[2] <= item_r.ctrl_x;
          win_y_r[0] <= win_y_r[1];
          win_y_r[1] <= win_y_r[2];
          win_y_r[2] <= item_r.ctrl_y;
          win_p_r[0] <= win_p_r[1];
          win_p_r[1] <= win_p_r[2];
          win_p_r[2] <= item_r.ctrl_pressure;
        end
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

/* test/catmull_rom_stroke_sampler_top_test.sv */
// Self-checking testbench for the Catmull-Rom stroke sampler top level.
`timescale 1ns / 100ps

module catmull_rom_stroke_sampler_top_test;
  import crss_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  catmull_rom_stroke_sampler_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Stimulus and expected samples.
  in_item_t  ctrl_q[$];
  out_item_t sample_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int mismatches;
  int ctrls_taken;
  int samples_seen;
  longint cycles;

  // Predicted block state.
  longint    win_x[3];
  longint    win_y[3];
  longint    win_p[3];
  int        ctrl_count;
  bit [15:0] spacing_r;
  bit [8:0]  curv_r;

  // Generate the clock.
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One axis of the curve blended toward the chord, rounded to an integer coordinate.
  function automatic longint blend_axis(longint p0, longint p1, longint p2,
                                        longint p3, longint t, longint cv);
    longint a, b, c, s2, s1, crv2, lin2, v;
    a    = p2 - p0;
    b    = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c    = -p0 + 3 * p1 - 3 * p2 + p3;
    s2   = b * 65536 + c * t;
    s1   = a * 65536 + ((s2 * t) >>> 16);
    crv2 = 2 * p1 * 65536 + ((s1 * t) >>> 16);
    lin2 = 2 * (p1 * 65536 + (p2 - p1) * t);
    v    = lin2 * 256 + (crv2 - lin2) * cv;
    return (v + (longint'(1) <<< 24)) >>> 25;
  endfunction

  // Queue the samples of one segment from p1 to p2.
  task automatic sample_segment(longint x0, longint x1, longint x2, longint x3,
                                longint y0, longint y1, longint y2, longint y3,
                                longint pr1, longint pr2, int first);
    longint dx, dy, d2, s, steps, cv, t, p;
    out_item_t o;
    dx = x2 - x1;
    dy = y2 - y1;
    d2 = dx * dx + dy * dy;
    s = (spacing_r < 2) ? 2 : spacing_r;
    cv = (curv_r > 256) ? 256 : curv_r;
    steps = MAX_STEPS;
    for (longint m = MAX_STEPS; m >= 1; m--)
      if (m * m * s * s >= d2) steps = m;
    for (longint i = first; i <= steps; i++) begin
      t = (i * 65536) / steps;
      p = (pr1 * 65536 + (pr2 - pr1) * t + 32768) >>> 16;
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      o.sample_x = sat16(blend_axis(x0, x1, x2, x3, t, cv));
      o.sample_y = sat16(blend_axis(y0, y1, y2, y3, t, cv));
      o.sample_pressure = p[15:0];
      o.run_last = 1'b0;
      sample_q = {sample_q, o};
    end
  endtask

  // Advance the predicted window by one accepted control point.
  task automatic take_ctrl(in_item_t c);
    longint x, y, pr;
    int prior_n, j0;
    out_item_t o;
    x = c.ctrl_x;
    y = c.ctrl_y;
    pr = c.ctrl_pressure;
    prior_n = sample_q.size();
    if (ctrl_count >= 2) begin
      j0 = (ctrl_count == 2) ? 1 : 0;
      sample_segment(win_x[j0], win_x[1], win_x[2], x,
                     win_y[j0], win_y[1], win_y[2], y,
                     win_p[1], win_p[2], (ctrl_count == 2) ? 0 : 1);
    end
    if (c.stroke_end) begin
      if (ctrl_count == 0) begin
        o.sample_x = c.ctrl_x;
        o.sample_y = c.ctrl_y;
        o.sample_pressure = c.ctrl_pressure;
        o.run_last = 1'b0;
        sample_q = {sample_q, o};
      end else begin
        j0 = (ctrl_count == 1) ? 2 : 1;
        sample_segment(win_x[j0], win_x[2], x, x, win_y[j0], win_y[2], y, y,
                       win_p[2], pr, (ctrl_count == 1) ? 0 : 1);
      end
      ctrl_count = 0;
    end else begin
      win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = x;
      win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = y;
      win_p[0] = win_p[1]; win_p[1] = win_p[2]; win_p[2] = pr;
      if (ctrl_count < 3) ctrl_count++;
    end
    if (sample_q.size() > prior_n)
      sample_q[sample_q.size() - 1].run_last = 1'b1;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d (sample %0d)", what, got, want,
             samples_seen);
    mismatches++;
  endtask

  // Offer control points from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (ctrl_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= ctrl_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted item.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      take_ctrl(in_data);
      ctrls_taken++;
    end
  end

  // Count down a long receiver hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check samples and drive the output stall.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        report("unexpected sample count", 1, 0);
      end else begin
        want = sample_q.pop_front();
        if (out_data.sample_x !== want.sample_x)
          report("sample_x", out_data.sample_x, want.sample_x);
        if (out_data.sample_y !== want.sample_y)
          report("sample_y", out_data.sample_y, want.sample_y);
        if (out_data.sample_pressure !== want.sample_pressure)
          report("sample_pressure", out_data.sample_pressure,
                 want.sample_pressure);
        if (out_data.run_last !== want.run_last)
          report("run_last", out_data.run_last, want.run_last);
      end
      samples_seen++;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("catmull_rom_stroke_sampler_top_test NOT OK");
      $finish;
    end
  end

  task automatic add_ctrl(int x, int y, int p, bit e);
    in_item_t c;
    c.ctrl_x = x[15:0];
    c.ctrl_y = y[15:0];
    c.ctrl_pressure = p[15:0];
    c.stroke_end = e;
    ctrl_q = {ctrl_q, c};
  endtask

  // Wait until nothing is pending or expected, then let the block settle.
  task automatic drain();
    while (ctrl_q.size() != 0 || in_valid || sample_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPACING) spacing_r = val;
    else curv_r = val[8:0];
    cfg_valid <= 1'b0;
  endtask

  // Random strokes: mostly short random walks, some wild jumps.
  task automatic add_strokes(int count, int reach);
    int x, y, len;
    x = $urandom_range(65535) - 32768;
    y = $urandom_range(65535) - 32768;
    while (count > 0) begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len && count > 0; k++) begin
        if ($urandom_range(7) == 0) begin
          x = $urandom_range(65535) - 32768;
          y = $urandom_range(65535) - 32768;
        end else begin
          x += $urandom_range(2 * reach) - reach;
          y += $urandom_range(2 * reach) - reach;
          if (x > 32767) x = 32767;
          if (x < -32768) x = -32768;
          if (y > 32767) y = 32767;
          if (y < -32768) y = -32768;
        end
        add_ctrl(x, y, $urandom_range(65535), (k == len - 1));
        count--;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SPACING;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0; hold_seen = 0; hold_left = 0;
    mismatches = 0; ctrls_taken = 0; samples_seen = 0; cycles = 0;
    win_x = '{0, 0, 0}; win_y = '{0, 0, 0}; win_p = '{0, 0, 0};
    ctrl_count = 0;
    spacing_r = SPACING_RST;
    curv_r = CURVATURE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lone control, two-point stroke, zero chord, extremes.
    add_ctrl(-32768, 32767, 65535, 1'b1);
    add_ctrl(32767, -32768, 0, 1'b1);
    add_ctrl(0, 0, 0, 1'b0);
    add_ctrl(100, -50, 65535, 1'b1);
    add_ctrl(5, 5, 1000, 1'b0);
    add_ctrl(5, 5, 2000, 1'b0);
    add_ctrl(5, 5, 3000, 1'b1);
    add_ctrl(-32768, -32768, 0, 1'b0);
    add_ctrl(32767, 32767, 65535, 1'b0);
    add_ctrl(-32768, 32767, 0, 1'b0);
    add_ctrl(32767, -32768, 65535, 1'b0);
    add_ctrl(0, 0, 32768, 1'b1);
    drain();
    write_reg(CFG_SPACING, 16'd0);
    write_reg(CFG_CURVATURE, 16'd0);
    add_ctrl(-32768, 0, 0, 1'b0);
    add_ctrl(32767, 40, 65535, 1'b0);
    add_ctrl(-32768, 80, 0, 1'b1);
    drain();
    write_reg(CFG_SPACING, 16'd65535);
    write_reg(CFG_CURVATURE, 16'd511);
    add_ctrl(1, 2, 3, 1'b0);
    add_ctrl(30000, -30000, 60000, 1'b0);
    add_ctrl(-30000, 30000, 10, 1'b0);
    add_ctrl(32767, 32767, 65535, 1'b1);
    drain();

    // Random, sender idles less than receiver; long hold-off fills the block.
    write_reg(CFG_SPACING, 16'd64);
    write_reg(CFG_CURVATURE, 16'd256);
    send_idle_pct = 23;
    recv_idle_pct = 45;
    add_strokes(90, 1500);
    repeat (50) @(posedge clk);
    hold_req++;
    drain();

    // Random, roles swapped; pause mid-phase until every sample is back.
    write_reg(CFG_SPACING, 16'd1);
    write_reg(CFG_CURVATURE, 16'd128);
    send_idle_pct = 45;
    recv_idle_pct = 23;
    add_strokes(45, 200);
    drain();
    write_reg(CFG_SPACING, 16'd300);
    add_strokes(45, 8000);
    drain();

    // Random, no idling.
    write_reg(CFG_SPACING, 16'd2);
    write_reg(CFG_CURVATURE, 16'd300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_strokes(90, 60);

    while (ctrl_q.size() != 0 || in_valid || sample_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d control points and %0d samples over several", ctrls_taken,
             samples_seen);
    $display("spacing/curvature settings and idle patterns, %0d mismatches", mismatches);
    if (mismatches == 0 && sample_q.size() == 0)
      $display("catmull_rom_stroke_sampler_top_test OK");
    else
      $display("catmull_rom_stroke_sampler_top_test NOT OK");
    $finish;
  end

endmodule
